// ===== rtl/weekly_switch_time_scheduler_top_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion helpers for the weekly switch time scheduler.
// ----------------------------------------------------------------------------
`ifndef WEEKLY_SWITCH_TIME_SCHEDULER_TOP_MACROS_SVH
`define WEEKLY_SWITCH_TIME_SCHEDULER_TOP_MACROS_SVH

`ifndef ASSERT_OFF
`define WSTS_ASSERT(name, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("wsts assertion failed");
`define WSTS_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wsts implication failed");
`else
`define WSTS_ASSERT(name, prop)
`define WSTS_ASSERT_IMP(name, ante, cons)
`endif

`endif

// ===== rtl/wsts_pkg.sv =====
// ----------------------------------------------------------------------------
// wsts_pkg
// Types, constants and helpers of the weekly switch time scheduler.
// ----------------------------------------------------------------------------
package wsts_pkg;

    localparam int POINTS_PER_CHANNEL = 16;
    localparam int CHANNELS           = 4;
    localparam int MINUTES_PER_HOUR   = 60;
    localparam int HOURS_PER_DAY      = 24;

    localparam int STORE_DEPTH = CHANNELS * 2 * POINTS_PER_CHANNEL;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int IDX_W       = (POINTS_PER_CHANNEL > 1) ? $clog2(POINTS_PER_CHANNEL) : 1;
    localparam int CNT_W       = $clog2(POINTS_PER_CHANNEL + 1);
    localparam int PT_W        = 14;
    localparam int NOW_W       = 16;
    localparam int BASE_W      = 9;
    localparam int HOUR_W      = 7;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 5;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_TICK  = 1'b1;
    localparam logic KIND_ON   = 1'b0;
    localparam logic KIND_OFF  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_HOUR_OFFSET       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RADIATOR_COUNT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FLOOR_COUNT       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CIRCULATION_COUNT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SHOWER_COUNT      = 3'd4;

    localparam logic [1:0] CH_RADIATOR    = 2'd0;
    localparam logic [1:0] CH_FLOOR       = 2'd1;
    localparam logic [1:0] CH_CIRCULATION = 2'd2;
    localparam logic [1:0] CH_SHOWER      = 2'd3;

    localparam logic signed [4:0] HOUR_OFFSET_RESET = 5'sd1;

    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [CNT_W-1:0]  cnt_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_NOW,
        ST_CHAN,
        ST_OFF,
        ST_ON,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic        command;
        logic [1:0]  channel;
        logic        point_kind;
        logic [3:0]  point_index;
        logic [13:0] point_time;
        logic [2:0]  weekday;
        logic [4:0]  clock_hour;
        logic [5:0]  clock_minute;
        logic [5:0]  clock_second;
    } item_t;

    typedef struct packed {
        logic radiator_normal;
        logic floor_normal;
        logic circulation_on;
        logic shower_active;
        logic second_changed;
        logic minute_changed;
        logic hour_changed;
    } result_t;

    typedef struct packed {
        logic            we;
        addr_t           waddr;
        logic [PT_W-1:0] wdata;
        addr_t           raddr;
    } store_req_t;

    function automatic addr_t slot_addr(input logic [1:0] chan, input logic kind,
                                        input int idx);
        int slot;
        slot = (int'(chan) * 2 + int'(kind)) * POINTS_PER_CHANNEL + idx;
        return ADDR_W'(slot);
    endfunction

    function automatic cnt_t sat_count(input logic [CFG_DATA_W-1:0] c);
        if (int'(c) > POINTS_PER_CHANNEL)
            return CNT_W'(POINTS_PER_CHANNEL);
        else
            return CNT_W'(c);
    endfunction

endpackage

// ===== rtl/wsts_if.sv =====
// ----------------------------------------------------------------------------
// wsts_if
// Valid/ready request channels for input items and results.
// ----------------------------------------------------------------------------
interface wsts_item_if import wsts_pkg::*; ();
    logic  valid;
    logic  ready;
    item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface wsts_result_if import wsts_pkg::*; ();
    logic    valid;
    logic    ready;
    result_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/wsts_store.sv =====
// ----------------------------------------------------------------------------
// wsts_store
// Switch point memory, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module wsts_store import wsts_pkg::*; (
    input  logic            clk,
    input  store_req_t      req,
    output logic [PT_W-1:0] rdata
);

    logic [PT_W-1:0] mem [STORE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        rdata <= mem[req.raddr];
    end

endmodule

// ===== rtl/wsts_cmp.sv =====
// ----------------------------------------------------------------------------
// wsts_cmp
// Shared signed compare of the minute of week against a stored point.
// ----------------------------------------------------------------------------
module wsts_cmp import wsts_pkg::*; (
    input  logic signed [NOW_W-1:0] now,
    input  logic        [PT_W-1:0]  point,
    output logic                    le
);

    logic signed [NOW_W-1:0] point_s;

    assign point_s = $signed({{(NOW_W - PT_W){1'b0}}, point});
    assign le      = (now <= point_s);

endmodule

// ===== rtl/weekly_switch_time_scheduler_top.sv =====
// ----------------------------------------------------------------------------
// weekly_switch_time_scheduler_top: a write goes to the point store on acceptance;
// a tick result loads into the result register after the scan of every channel,
// once that register is free; the scan is paced by the point store's single read
// port and the single compare unit, one point per cycle. The next request is taken
// the cycle after the result loads; a held result stalls the scan end.
// Reset: hour offset 1, counts 0, change history 0; point store undefined.
// ----------------------------------------------------------------------------
`include "weekly_switch_time_scheduler_top_macros.svh"

module weekly_switch_time_scheduler_top import wsts_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    wsts_item_if.sink             item,
    wsts_result_if.source         result
);

    state_t                  state_reg, state_next;
    logic [1:0]              chan_reg, chan_next;
    logic [IDX_W-1:0]        idx_reg, idx_next;
    logic [CHANNELS-1:0]     act_reg, act_next;
    logic signed [BASE_W-1:0] base_reg, base_next;
    logic signed [NOW_W-1:0] now_reg, now_next;
    logic [5:0]              minute_reg;
    logic [2:0]              flags_reg;
    logic [5:0]              last_second_reg, last_minute_reg, last_hour_reg;
    logic signed [4:0]       hour_offset_reg;
    logic [CFG_DATA_W-1:0]   count_reg [CHANNELS];
    logic                    result_valid_reg;
    result_t                 result_data_reg;

    store_req_t              store_req;
    logic [PT_W-1:0]         rdata;
    logic                    cmp_le;
    logic                    item_acc;
    logic                    tick_acc;
    logic                    load;
    logic                    chan_last;
    logic                    idx_last;
    cnt_t                    n_cur;
    logic signed [HOUR_W-1:0] hour_s;

    wsts_store u_store (
        .clk   (clk),
        .req   (store_req),
        .rdata (rdata)
    );

    wsts_cmp u_cmp (
        .now   (now_reg),
        .point (rdata),
        .le    (cmp_le)
    );

    assign item.ready = (state_reg == ST_IDLE);
    assign item_acc   = item.valid && item.ready;
    assign tick_acc   = item_acc && (item.data.command == CMD_TICK);

    assign hour_s    = $signed({2'b00, item.data.clock_hour}) + HOUR_W'(hour_offset_reg);
    assign n_cur     = sat_count(count_reg[chan_reg]);
    assign chan_last = (chan_reg == 2'(CHANNELS - 1));
    assign idx_last  = ((int'(idx_reg) + 1) == int'(n_cur));

    assign result.valid = result_valid_reg;
    assign result.data  = result_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hour_offset_reg <= HOUR_OFFSET_RESET;
            for (int c = 0; c < CHANNELS; c++)
            begin
                count_reg[c] <= '0;
            end
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_HOUR_OFFSET:       hour_offset_reg <= $signed(cfg_data);
                REG_RADIATOR_COUNT:    count_reg[CH_RADIATOR] <= cfg_data;
                REG_FLOOR_COUNT:       count_reg[CH_FLOOR] <= cfg_data;
                REG_CIRCULATION_COUNT: count_reg[CH_CIRCULATION] <= cfg_data;
                REG_SHOWER_COUNT:      count_reg[CH_SHOWER] <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            chan_reg         <= '0;
            idx_reg          <= '0;
            last_second_reg  <= '0;
            last_minute_reg  <= '0;
            last_hour_reg    <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            chan_reg  <= chan_next;
            idx_reg   <= idx_next;
            if (tick_acc)
            begin
                last_second_reg <= item.data.clock_second;
                last_minute_reg <= item.data.clock_minute;
                last_hour_reg   <= hour_s[5:0];
            end
            if (load)
                result_valid_reg <= 1'b1;
            else if (result.ready)
                result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg  <= act_next;
        base_reg <= base_next;
        now_reg  <= now_next;
        if (tick_acc)
        begin
            minute_reg <= item.data.clock_minute;
            flags_reg  <= {item.data.clock_second != last_second_reg,
                           item.data.clock_minute != last_minute_reg,
                           hour_s[5:0] != last_hour_reg};
        end
        if (load)
        begin
            result_data_reg.radiator_normal <= act_reg[CH_RADIATOR];
            result_data_reg.floor_normal    <= act_reg[CH_FLOOR];
            result_data_reg.circulation_on  <= act_reg[CH_CIRCULATION];
            result_data_reg.shower_active   <= act_reg[CH_SHOWER];
            result_data_reg.second_changed  <= flags_reg[2];
            result_data_reg.minute_changed  <= flags_reg[1];
            result_data_reg.hour_changed    <= flags_reg[0];
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        chan_next       = chan_reg;
        idx_next        = idx_reg;
        act_next        = act_reg;
        base_next       = base_reg;
        now_next        = now_reg;
        load            = 1'b0;
        store_req.we    = 1'b0;
        store_req.waddr = slot_addr(item.data.channel, item.data.point_kind,
                                    int'(item.data.point_index));
        store_req.wdata = item.data.point_time;
        store_req.raddr = slot_addr(chan_reg, KIND_OFF, 0);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (tick_acc)
                begin
                    base_next  = BASE_W'($signed({1'b0, item.data.weekday}))
                               * BASE_W'(HOURS_PER_DAY) + BASE_W'(hour_s);
                    state_next = ST_NOW;
                end
                else if (item_acc
                         && (int'(item.data.point_index) < POINTS_PER_CHANNEL))
                begin
                    store_req.we = 1'b1;
                end
            end
            ST_NOW:
            begin
                now_next   = NOW_W'(base_reg) * NOW_W'(MINUTES_PER_HOUR)
                           + NOW_W'($signed({1'b0, minute_reg}));
                chan_next  = '0;
                state_next = ST_CHAN;
            end
            ST_CHAN:
            begin
                idx_next = '0;
                if (n_cur == '0)
                begin
                    act_next[chan_reg] = 1'b0;
                    chan_next  = chan_reg + 2'd1;
                    state_next = chan_last ? ST_DONE : ST_CHAN;
                end
                else
                begin
                    state_next = ST_OFF;
                end
            end
            ST_OFF:
            begin
                if (cmp_le)
                begin
                    store_req.raddr = slot_addr(chan_reg, KIND_ON, int'(idx_reg));
                    state_next      = ST_ON;
                end
                else if (idx_last)
                begin
                    act_next[chan_reg] = 1'b0;
                    chan_next  = chan_reg + 2'd1;
                    state_next = chan_last ? ST_DONE : ST_CHAN;
                end
                else
                begin
                    idx_next        = IDX_W'(int'(idx_reg) + 1);
                    store_req.raddr = slot_addr(chan_reg, KIND_OFF, int'(idx_reg) + 1);
                end
            end
            ST_ON:
            begin
                act_next[chan_reg] = !cmp_le;
                chan_next  = chan_reg + 2'd1;
                state_next = chan_last ? ST_DONE : ST_CHAN;
            end
            ST_DONE:
            begin
                if (!result_valid_reg || result.ready)
                begin
                    load       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `WSTS_ASSERT_IMP(a_result_from_done, $rose(result_valid_reg), $past(state_reg == ST_DONE))
    `WSTS_ASSERT_IMP(a_write_no_scan, item_acc && !tick_acc, ##1 (state_reg == ST_IDLE))
    `WSTS_ASSERT_IMP(a_scan_in_range, state_reg == ST_OFF, int'(idx_reg) < int'(n_cur))
    `WSTS_ASSERT_IMP(a_no_store_write_busy, state_reg != ST_IDLE, !store_req.we)

endmodule
